@@ rtl/core/bmp_rle_decoder_macros.svh @@
// Assertion macros shared by the bitmap RLE decoder checkers.
// Needs no package; each macro takes its clock and properties as arguments.
`ifndef BMP_RLE_DECODER_MACROS_SVH
`define BMP_RLE_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset
`define BMPRLE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check a property on every clock edge, reset included
`define BMPRLE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ rtl/core/bmprle_pkg.sv @@
// Shared constants and types for the bitmap RLE8/RLE4 decoder.
// Used by bmp_rle_decoder and its checker; depends on nothing.
package bmprle_pkg;

  // Default width of the linear write offset
  localparam int unsigned OFFSET_BITS_DEF = 24;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned LIMIT_W = 2 * DIM_W;
  localparam int unsigned TDATA_W = 48;
  localparam int unsigned TUSER_W = 2;

  // Configuration port
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;
  localparam logic [1:0] REG_RLE4_MODE    = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 26'd307200;

  // Result kinds
  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  // Nibble masks
  localparam logic [BYTE_W-1:0] NIB_LO = 8'h0F;
  localparam logic [BYTE_W-1:0] NIB_HI = 8'hF0;

  // One result item
  typedef struct packed {
    logic              beyond_image;
    logic              result_kind;
    logic [BYTE_W-1:0] value_odd;
    logic [BYTE_W-1:0] value_even;
    logic [BYTE_W-1:0] run_length;
    logic [PIX_W-1:0]  pixel_offset;
  } result_t;

endpackage

@@ rtl/core/bmp_rle_decoder.sv @@
// Bitmap RLE8/RLE4 stream decoder: one compressed byte in, at most one pixel run out.
// Depends on bmprle_pkg.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-------------------------------------------
//  s_       | in        | s_tvalid/tready  | tdata: data_byte; tuser: start_image
//  m_       | out       | m_tvalid/tready  | tdata: offset,length,even,odd; tuser: kind,beyond
//  apb      | in        | psel/penable     | rle4_mode, image_width, image_height
//
// One byte is taken per cycle while the skid slot is empty; its result, if any, is registered.
// The parse is a single pass through one 16x13 multiplier (line start or delta move) and one
// add and compare (beyond-image flag) between input and result.
// A two-entry output (register plus skid) keeps input flowing while one result stalls.
// Synchronous reset clears parse state, position and configuration; no clearing pass.
module bmp_rle_decoder #(
  parameter int unsigned OFFSET_BITS = bmprle_pkg::OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bmprle_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] start_image
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [23:0] pixel_offset, [31:24] run_length, [39:32] value_even, [47:40] value_odd
  output logic [bmprle_pkg::TDATA_W-1:0]    m_tdata,
  output logic [bmprle_pkg::TUSER_W-1:0]    m_tuser,   // [0] result_kind, [1] beyond_image
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bmprle_pkg::PADDR_W-1:0]    paddr,
  input  logic [bmprle_pkg::PDATA_W-1:0]    pwdata,
  output logic [bmprle_pkg::PDATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int unsigned BW     = bmprle_pkg::BYTE_W;
  localparam int unsigned DW     = bmprle_pkg::DIM_W;
  localparam int unsigned LW     = bmprle_pkg::LINE_W;
  localparam int unsigned PROD_W = LW + DW;
  localparam int unsigned WIDE_W = (OFFSET_BITS + 1 > PROD_W + 1) ? OFFSET_BITS + 1
                                                                   : PROD_W + 1;

  // Parse phases
  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_CODE  = 3'd1;
  localparam logic [2:0] PH_DX    = 3'd2;
  localparam logic [2:0] PH_DY    = 3'd3;
  localparam logic [2:0] PH_ABS   = 3'd4;
  localparam logic [2:0] PH_PAD   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;

  // Configuration registers
  logic                                rle4_mode;
  logic [DW-1:0]                       image_width;
  logic [DW-1:0]                       image_height;
  logic [bmprle_pkg::LIMIT_W-1:0]      pixel_limit;
  logic                                cfg_write;

  // Parse state
  logic [2:0]             parse_phase, parse_phase_next;
  logic [BW-1:0]          held_count, held_count_next;
  logic [BW-1:0]          absolute_left, absolute_left_next;
  logic                   pad_pending, pad_pending_next;
  logic [BW-1:0]          held_delta_x, held_delta_x_next;
  logic [LW-1:0]          line_index, line_index_next;
  logic [OFFSET_BITS-1:0] write_offset, write_offset_next;

  // State as seen by this item, after an optional start_image clear
  logic [2:0]             cur_phase;
  logic [BW-1:0]          cur_count;
  logic [BW-1:0]          cur_left;
  logic                   cur_pad;
  logic [BW-1:0]          cur_dx;
  logic [LW-1:0]          cur_line;
  logic [OFFSET_BITS-1:0] cur_offset;

  logic                   in_accept;
  logic [BW-1:0]          b;
  logic [LW-1:0]          line_inc;
  logic [LW-1:0]          mul_a;
  logic [PROD_W-1:0]      mul_p;
  logic [WIDE_W-1:0]      off_wide;
  logic [BW:0]            b_plus1;
  logic [BW-1:0]          abs_len;

  bmprle_pkg::result_t    res;
  logic                   res_valid;
  bmprle_pkg::result_t    out_res, skid_res;
  logic                   out_valid, skid_valid;
  logic                   out_pop;

  // Configuration port: zero-wait, write on the access cycle
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  // Update the image size product together with the size it depends on
  always_ff @(posedge clk) begin
    if (rst) begin
      rle4_mode    <= 1'b0;
      image_width  <= bmprle_pkg::WIDTH_RESET;
      image_height <= bmprle_pkg::HEIGHT_RESET;
      pixel_limit  <= bmprle_pkg::LIMIT_RESET;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          bmprle_pkg::REG_RLE4_MODE:    rle4_mode <= pwdata[0];
          bmprle_pkg::REG_IMAGE_WIDTH: begin
            image_width <= pwdata[DW-1:0];
            pixel_limit <= pwdata[DW-1:0] * image_height;
          end
          bmprle_pkg::REG_IMAGE_HEIGHT: begin
            image_height <= pwdata[DW-1:0];
            pixel_limit  <= image_width * pwdata[DW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[3:2])
      bmprle_pkg::REG_RLE4_MODE:    prdata = {{(bmprle_pkg::PDATA_W-1){1'b0}}, rle4_mode};
      bmprle_pkg::REG_IMAGE_WIDTH:  prdata = {{(bmprle_pkg::PDATA_W-DW){1'b0}}, image_width};
      bmprle_pkg::REG_IMAGE_HEIGHT: prdata = {{(bmprle_pkg::PDATA_W-DW){1'b0}}, image_height};
      default:                      prdata = '0;
    endcase
  end

  // Input handshake: stall only while the skid slot holds a result
  assign s_tready  = ~skid_valid;
  assign in_accept = s_tvalid & s_tready;
  assign b         = s_tdata;

  // Apply start_image before decoding this byte
  always_comb begin
    if (s_tuser) begin
      cur_phase  = PH_COUNT;
      cur_count  = '0;
      cur_left   = '0;
      cur_pad    = 1'b0;
      cur_dx     = '0;
      cur_line   = '0;
      cur_offset = '0;
    end else begin
      cur_phase  = parse_phase;
      cur_count  = held_count;
      cur_left   = absolute_left;
      cur_pad    = pad_pending;
      cur_dx     = held_delta_x;
      cur_line   = line_index;
      cur_offset = write_offset;
    end
  end

  // Shared multiplier: next line start at end of line, dy times width on a delta
  assign line_inc = cur_line + LW'(1);
  assign mul_a    = (cur_phase == PH_CODE) ? line_inc : LW'(b);
  assign mul_p    = mul_a * image_width;
  assign off_wide = WIDE_W'(cur_offset);
  assign b_plus1  = {1'b0, b} + (BW+1)'(1);

  // Pixels taken from one absolute byte
  always_comb begin
    if (rle4_mode) begin
      abs_len = (cur_left >= BW'(2)) ? BW'(2) : cur_left;
    end else begin
      abs_len = (cur_left >= BW'(1)) ? BW'(1) : BW'(0);
    end
  end

  // Decode one byte
  always_comb begin
    parse_phase_next   = cur_phase;
    held_count_next    = cur_count;
    absolute_left_next = cur_left;
    pad_pending_next   = cur_pad;
    held_delta_x_next  = cur_dx;
    line_index_next    = cur_line;
    write_offset_next  = cur_offset;
    res_valid          = 1'b0;
    res.result_kind    = bmprle_pkg::KIND_RUN;
    res.pixel_offset   = off_wide[bmprle_pkg::PIX_W-1:0];
    res.run_length     = '0;
    res.value_even     = '0;
    res.value_odd      = '0;
    res.beyond_image   = 1'b0;

    case (cur_phase)
      PH_COUNT: begin
        held_count_next  = b;
        parse_phase_next = PH_CODE;
      end
      PH_CODE: begin
        parse_phase_next = PH_COUNT;
        if (cur_count != '0) begin
          // Encoded run
          res_valid      = 1'b1;
          res.run_length = cur_count;
          if (rle4_mode) begin
            res.value_even = (b & bmprle_pkg::NIB_HI) >> 4;
            res.value_odd  = b & bmprle_pkg::NIB_LO;
          end else begin
            res.value_even = b;
            res.value_odd  = b;
          end
          write_offset_next = cur_offset + OFFSET_BITS'(cur_count);
        end else if (b == BW'(0)) begin
          // End of line: jump to the start of the next line
          line_index_next   = line_inc;
          write_offset_next = OFFSET_BITS'(WIDE_W'(mul_p));
        end else if (b == BW'(1)) begin
          // End of bitmap: ignore bytes until the next image
          res_valid        = 1'b1;
          res.result_kind  = bmprle_pkg::KIND_END;
          parse_phase_next = PH_DONE;
        end else if (b == BW'(2)) begin
          parse_phase_next = PH_DX;
        end else begin
          // Absolute run: padding fixed by the mode at its start
          absolute_left_next = b;
          pad_pending_next   = rle4_mode ? b_plus1[1] : b[0];
          parse_phase_next   = PH_ABS;
        end
      end
      PH_DX: begin
        held_delta_x_next = b;
        parse_phase_next  = PH_DY;
      end
      PH_DY: begin
        line_index_next   = cur_line + LW'(b);
        write_offset_next = OFFSET_BITS'(off_wide + WIDE_W'(cur_dx) + WIDE_W'(mul_p));
        parse_phase_next  = PH_COUNT;
      end
      PH_ABS: begin
        res_valid      = 1'b1;
        res.run_length = abs_len;
        if (rle4_mode) begin
          res.value_even = (b & bmprle_pkg::NIB_HI) >> 4;
          res.value_odd  = (abs_len == BW'(2)) ? (b & bmprle_pkg::NIB_LO) : BW'(0);
        end else begin
          res.value_even = b;
        end
        write_offset_next  = cur_offset + OFFSET_BITS'(abs_len);
        absolute_left_next = cur_left - abs_len;
        if (cur_left == abs_len) begin
          parse_phase_next = cur_pad ? PH_PAD : PH_COUNT;
        end
      end
      PH_PAD: begin
        pad_pending_next = 1'b0;
        parse_phase_next = PH_COUNT;
      end
      default: ;
    endcase

    // Flag runs that reach past the image
    if (res.result_kind == bmprle_pkg::KIND_RUN) begin
      res.beyond_image = (off_wide + WIDE_W'(res.run_length)) > WIDE_W'(pixel_limit);
    end
  end

  // Advance parse state on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= PH_COUNT;
      held_count    <= '0;
      absolute_left <= '0;
      pad_pending   <= 1'b0;
      held_delta_x  <= '0;
      line_index    <= '0;
      write_offset  <= '0;
    end else if (in_accept) begin
      parse_phase   <= parse_phase_next;
      held_count    <= held_count_next;
      absolute_left <= absolute_left_next;
      pad_pending   <= pad_pending_next;
      held_delta_x  <= held_delta_x_next;
      line_index    <= line_index_next;
      write_offset  <= write_offset_next;
    end
  end

  // Output register with one skid slot behind it
  assign out_pop = out_valid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid && !out_pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_res <= skid_res;
      end
    end else if (in_accept && res_valid) begin
      if (out_valid && !out_pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.value_odd, out_res.value_even, out_res.run_length,
                     out_res.pixel_offset};
  assign m_tuser  = {out_res.beyond_image, out_res.result_kind};

endmodule

@@ rtl/core/bmprle_checker.sv @@
// Port-level assertions for bmp_rle_decoder, attached by bind.
// Depends on bmprle_pkg and bmp_rle_decoder_macros.svh.
`include "bmp_rle_decoder_macros.svh"

module bmprle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bmprle_pkg::TDATA_W-1:0] m_tdata,
  input logic [bmprle_pkg::TUSER_W-1:0] m_tuser
);

  logic out_stall;
  logic out_end;

  // Result waiting at a stalled receiver, end-of-bitmap result on the bus
  assign out_stall = m_tvalid & ~m_tready;
  assign out_end   = m_tvalid & (m_tuser[0] == bmprle_pkg::KIND_END);

  // A stalled result holds its payload
  `BMPRLE_ASSERT(a_out_hold, clk, rst, out_stall |=> m_tvalid && $stable({m_tuser, m_tdata}))

  // End of bitmap carries no pixels and no beyond-image flag
  `BMPRLE_ASSERT(a_end_empty, clk, rst, out_end |-> m_tdata[47:24] == 24'd0 && !m_tuser[1])

  // With no result waiting the input is never stalled
  `BMPRLE_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready)

  // Reset leaves no result pending
  `BMPRLE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid && s_tready)

endmodule

bind bmp_rle_decoder bmprle_checker u_bmprle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
